// ===== hdl/teev_pkg.sv =====
// teev_pkg: token codes, status codes, pending operator codes and the
// request/response structs shared by the evaluator top level and its serial unit.
// No dependencies.
`timescale 1ns / 1ps

package teev_pkg;

  // token port width, fixed by the channel definition
  localparam int TOKEN_W = 64;

  // token kinds
  localparam logic [2:0] KIND_NUM    = 3'd0;
  localparam logic [2:0] KIND_PLUS   = 3'd1;
  localparam logic [2:0] KIND_MINUS  = 3'd2;
  localparam logic [2:0] KIND_TIMES  = 3'd3;
  localparam logic [2:0] KIND_DIVIDE = 3'd4;
  localparam logic [2:0] KIND_EQUALS = 3'd5;

  // result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_UNEXPECTED = 2'd1;
  localparam logic [1:0] ST_DIVZERO    = 2'd2;
  localparam logic [1:0] ST_SATURATED  = 2'd3;

  // pending multiplicative operator
  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_MUL  = 2'd1;
  localparam logic [1:0] OP_DIV  = 2'd2;

  // command into the serial multiply/divide unit
  typedef struct packed {
    logic start;
    logic is_div;
  } mdu_req_t;

  // status back from the serial multiply/divide unit
  typedef struct packed {
    logic done;
    logic big;
  } mdu_rsp_t;

endpackage

// ===== hdl/teev_muldiv.sv =====
// teev_muldiv: bit-serial magnitude multiply (shift-add) and restoring divide
// for fixed-point operands, one bit per cycle through a shared adder.
// Depends on teev_pkg for the request/response structs.
`timescale 1ns / 1ps

module teev_muldiv #(
  parameter int VALUE_WIDTH = 64,
  parameter int FRAC_BITS   = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  teev_pkg::mdu_req_t     req,
  input  logic [VALUE_WIDTH-1:0] a,
  input  logic [VALUE_WIDTH-1:0] b,
  output teev_pkg::mdu_rsp_t     rsp,
  output logic [VALUE_WIDTH-1:0] mag
);

  localparam int W   = VALUE_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int NW  = W + F;
  localparam int CW  = $clog2(NW + 1);
  localparam int PEW = 2 * W + F;

  logic          busy;
  logic          done;
  logic          is_div;
  logic [CW-1:0] cnt;
  logic [W:0]    acc;
  logic [NW-1:0] sreg;
  logic [W-1:0]  opnd;

  logic [W:0]     trial;
  logic [W+1:0]   base;
  logic [W+1:0]   opnd_x;
  logic [W+1:0]   sum;
  logic           qbit;
  logic [PEW-1:0] prod_ext;
  logic [PEW-1:0] prod_q;
  logic [NW-1:0]  quot_hi;

  // one step of the shared adder: add for multiply, subtract for divide
  always_comb begin
    trial  = {acc[W-1:0], sreg[NW-1]};
    base   = is_div ? {1'b0, trial} : {1'b0, acc};
    opnd_x = is_div ? ~{2'b00, opnd} : (sreg[0] ? {2'b00, opnd} : '0);
    sum    = base + opnd_x + (W + 2)'(is_div);
    qbit   = ~sum[W+1];
  end

  // sequencer and shift registers
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.is_div ? CW'(NW) : CW'(W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      is_div <= req.is_div;
      acc    <= '0;
      if (req.is_div) begin
        sreg <= NW'(a) << F;
        opnd <= b;
      end else begin
        sreg <= NW'(b);
        opnd <= a;
      end
    end else if (busy) begin
      if (is_div) begin
        // restoring divide: numerator bits leave at the top, quotient bits enter below
        acc  <= qbit ? sum[W:0] : trial;
        sreg <= {sreg[NW-2:0], qbit};
      end else begin
        // shift-add multiply: product bits enter at the top as multiplier bits leave
        acc  <= {1'b0, sum[W:1]};
        sreg <= {sum[0], sreg[NW-1:1]};
      end
    end
  end

  // scale the product back by the fraction bits, flag anything past the word
  always_comb begin
    prod_ext = PEW'({acc[W-1:0], sreg[NW-1 -: W]});
    prod_q   = prod_ext >> F;
    quot_hi  = sreg >> W;
  end

  assign mag      = is_div ? sreg[W-1:0] : prod_q[W-1:0];
  assign rsp.done = done;
  assign rsp.big  = is_div ? (quot_hi != '0) : ((prod_q >> W) != '0);

endmodule

// ===== hdl/teev_fold.sv =====
// teev_fold: folds the current term into the running sum (add or subtract)
// with saturation to the value range and an overflow flag.
// No dependencies.
`timescale 1ns / 1ps

module teev_fold #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic signed [VALUE_WIDTH-1:0] sum,
  input  logic signed [VALUE_WIDTH-1:0] prod,
  input  logic                          sub,
  output logic signed [VALUE_WIDTH-1:0] result,
  output logic                          ovf
);

  localparam int W = VALUE_WIDTH;
  localparam logic signed [W-1:0]   VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]   VMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W+1:0]   EMAX = (W + 2)'(VMAX);
  localparam logic signed [W+1:0]   EMIN = (W + 2)'(VMIN);

  logic signed [W+1:0] s_ext;
  logic signed [W+1:0] p_ext;
  logic signed [W+1:0] total;

  // exact sum with two guard bits, then clamp
  always_comb begin
    s_ext  = (W + 2)'(sum);
    p_ext  = (W + 2)'(prod);
    total  = sub ? (s_ext - p_ext) : (s_ext + p_ext);
    ovf    = (total > EMAX) || (total < EMIN);
    result = ovf ? (total[W+1] ? VMIN : VMAX) : total[W-1:0];
  end

endmodule

// ===== hdl/token_expression_evaluator_core.sv =====
// Token expression evaluator: plus/minus/times/divide over signed fixed point.
// Plus, minus, equals and a number without pending operator are taken in the idle state.
// A number after times or divide starts the one-bit-a-cycle serial multiply/divide,
// and the token port stalls until it is done.
// Result registered: appears the cycle after the equals or error beat.
// Synchronous active-high reset clears the expression state and result valid.
`timescale 1ns / 1ps

module token_expression_evaluator_core #(
  parameter int VALUE_WIDTH = 64,
  parameter int FRAC_BITS   = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                token_valid,
  output logic                                token_stall,
  input  logic [2:0]                          token_kind,
  input  logic signed [teev_pkg::TOKEN_W-1:0] token_value,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic signed [teev_pkg::TOKEN_W-1:0] result_value,
  output logic [1:0]                          status
);

  localparam int W = VALUE_WIDTH;
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  localparam logic S_IDLE = 1'b0;
  localparam logic S_BUSY = 1'b1;

  // expression state
  logic                state, state_next;
  logic                expect_op, expect_op_next;
  logic                negate_pending, negate_pending_next;
  logic signed [W-1:0] running_sum, running_sum_next;
  logic signed [W-1:0] running_product, running_product_next;
  logic                additive_sign, additive_sign_next;
  logic [1:0]          pending_mul_op, pending_mul_op_next;
  logic                overflow_seen, overflow_seen_next;
  logic                res_sign, res_sign_next;

  // output register
  logic                                result_valid_next;
  logic signed [teev_pkg::TOKEN_W-1:0] result_value_next;
  logic [1:0]                          status_next;

  logic                tok_acc;
  logic                in_fits;
  logic signed [W-1:0] sat_val;
  logic                num_neg;
  logic [W-1:0]        num_mag;
  logic                nv;
  logic                prod_neg;
  logic [W-1:0]        prod_mag;

  logic                join_neg;
  logic [W-1:0]        join_mag;
  logic                join_big;
  logic                join_ovf;
  logic signed [W-1:0] join_val;

  logic signed [W-1:0] fold_val;
  logic                fold_ovf;

  logic                emit;
  logic signed [W-1:0] emit_val;
  logic [1:0]          emit_st;

  teev_pkg::mdu_req_t  mdu_req;
  teev_pkg::mdu_rsp_t  mdu_rsp;
  logic [W-1:0]        mdu_mag;

  // rebuild a signed value from sign and magnitude, clamping to the range
  function automatic logic [W:0] join_sm(input logic neg, input logic [W-1:0] mag,
                                         input logic big);
    logic [W-1:0] limit;
    logic [W-1:0] m;
    logic [W-1:0] v;
    logic         o;
    limit = neg ? VMIN : VMAX;
    o     = big || (mag > limit);
    m     = o ? limit : mag;
    v     = neg ? (~m + 1'b1) : m;
    return {o, v};
  endfunction

  assign tok_acc     = token_valid && !token_stall;
  assign token_stall = (state != S_IDLE) || (result_valid && result_stall);

  // incoming number clamped to the value range, split into sign and magnitude
  always_comb begin
    in_fits  = (token_value[teev_pkg::TOKEN_W-1:W-1] == '0) ||
               (token_value[teev_pkg::TOKEN_W-1:W-1] == '1);
    sat_val  = in_fits ? token_value[W-1:0] :
               (token_value[teev_pkg::TOKEN_W-1] ? VMIN : VMAX);
    num_neg  = sat_val[W-1];
    num_mag  = num_neg ? (~sat_val + 1'b1) : sat_val;
    nv       = num_neg ^ negate_pending;
    prod_neg = running_product[W-1];
    prod_mag = prod_neg ? (~running_product + 1'b1) : running_product;
  end

  // one shared rejoin: plain number in idle, serial result when busy
  assign join_neg = (state == S_BUSY) ? res_sign : nv;
  assign join_mag = (state == S_BUSY) ? mdu_mag : num_mag;
  assign join_big = (state == S_BUSY) && mdu_rsp.big;
  assign {join_ovf, join_val} = join_sm(join_neg, join_mag, join_big);

  teev_fold #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_fold (
    .sum   (running_sum),
    .prod  (running_product),
    .sub   (additive_sign),
    .result(fold_val),
    .ovf   (fold_ovf)
  );

  teev_muldiv #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_muldiv (
    .clk(clk),
    .rst(rst),
    .req(mdu_req),
    .a  (prod_mag),
    .b  (num_mag),
    .rsp(mdu_rsp),
    .mag(mdu_mag)
  );

  // token sequencing
  always_comb begin
    state_next           = state;
    expect_op_next       = expect_op;
    negate_pending_next  = negate_pending;
    running_sum_next     = running_sum;
    running_product_next = running_product;
    additive_sign_next   = additive_sign;
    pending_mul_op_next  = pending_mul_op;
    overflow_seen_next   = overflow_seen;
    res_sign_next        = res_sign;
    result_valid_next    = result_valid && result_stall;
    result_value_next    = result_value;
    status_next          = status;
    mdu_req              = '0;
    emit                 = 1'b0;
    emit_val             = '0;
    emit_st              = teev_pkg::ST_OK;

    case (state)
      S_IDLE: begin
        if (tok_acc) begin
          if (!expect_op) begin
            if (token_kind == teev_pkg::KIND_MINUS) begin
              negate_pending_next = ~negate_pending;
            end else if (token_kind != teev_pkg::KIND_NUM) begin
              emit    = 1'b1;
              emit_st = teev_pkg::ST_UNEXPECTED;
            end else if (pending_mul_op inside {teev_pkg::OP_MUL, teev_pkg::OP_DIV}) begin
              if (pending_mul_op == teev_pkg::OP_DIV && num_mag == '0) begin
                emit    = 1'b1;
                emit_st = teev_pkg::ST_DIVZERO;
              end else begin
                overflow_seen_next = overflow_seen || !in_fits;
                res_sign_next      = prod_neg ^ nv;
                mdu_req.start      = 1'b1;
                mdu_req.is_div     = (pending_mul_op == teev_pkg::OP_DIV);
                state_next         = S_BUSY;
              end
            end else begin
              running_product_next = join_val;
              overflow_seen_next   = overflow_seen || !in_fits || join_ovf;
              negate_pending_next  = 1'b0;
              pending_mul_op_next  = teev_pkg::OP_NONE;
              expect_op_next       = 1'b1;
            end
          end else begin
            case (token_kind)
              teev_pkg::KIND_TIMES: begin
                pending_mul_op_next = teev_pkg::OP_MUL;
                expect_op_next      = 1'b0;
              end
              teev_pkg::KIND_DIVIDE: begin
                pending_mul_op_next = teev_pkg::OP_DIV;
                expect_op_next      = 1'b0;
              end
              teev_pkg::KIND_PLUS, teev_pkg::KIND_MINUS: begin
                running_sum_next     = fold_val;
                running_product_next = '0;
                additive_sign_next   = (token_kind == teev_pkg::KIND_MINUS);
                pending_mul_op_next  = teev_pkg::OP_NONE;
                overflow_seen_next   = overflow_seen || fold_ovf;
                expect_op_next       = 1'b0;
              end
              teev_pkg::KIND_EQUALS: begin
                emit     = 1'b1;
                emit_val = fold_val;
                emit_st  = (overflow_seen || fold_ovf) ? teev_pkg::ST_SATURATED
                                                       : teev_pkg::ST_OK;
              end
              default: begin
                emit    = 1'b1;
                emit_st = teev_pkg::ST_UNEXPECTED;
              end
            endcase
          end
        end
      end
      S_BUSY: begin
        if (mdu_rsp.done) begin
          running_product_next = join_val;
          overflow_seen_next   = overflow_seen || join_ovf;
          negate_pending_next  = 1'b0;
          pending_mul_op_next  = teev_pkg::OP_NONE;
          expect_op_next       = 1'b1;
          state_next           = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // a result beat starts the expression over
    if (emit) begin
      expect_op_next       = 1'b0;
      negate_pending_next  = 1'b0;
      running_sum_next     = '0;
      running_product_next = '0;
      additive_sign_next   = 1'b0;
      pending_mul_op_next  = teev_pkg::OP_NONE;
      overflow_seen_next   = 1'b0;
      result_valid_next    = 1'b1;
      result_value_next    = teev_pkg::TOKEN_W'(emit_val);
      status_next          = emit_st;
    end
  end

  // control and expression registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      expect_op       <= 1'b0;
      negate_pending  <= 1'b0;
      running_sum     <= '0;
      running_product <= '0;
      additive_sign   <= 1'b0;
      pending_mul_op  <= teev_pkg::OP_NONE;
      overflow_seen   <= 1'b0;
      result_valid    <= 1'b0;
    end else begin
      state           <= state_next;
      expect_op       <= expect_op_next;
      negate_pending  <= negate_pending_next;
      running_sum     <= running_sum_next;
      running_product <= running_product_next;
      additive_sign   <= additive_sign_next;
      pending_mul_op  <= pending_mul_op_next;
      overflow_seen   <= overflow_seen_next;
      result_valid    <= result_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    res_sign     <= res_sign_next;
    result_value <= result_value_next;
    status       <= status_next;
  end

`ifndef SYNTHESIS
  // the serial unit only finishes while the sequencer waits for it
  a_done_in_busy: assert property (@(posedge clk) disable iff (rst)
    mdu_rsp.done |-> state == S_BUSY)
    else $error("serial unit finished outside the busy state");

  // error results carry a zero value
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status == teev_pkg::ST_UNEXPECTED || status == teev_pkg::ST_DIVZERO)
    |-> result_value == '0)
    else $error("error result with non-zero value");

  // a result beat leaves the expression state cleared
  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    emit |=> !expect_op && !negate_pending && running_sum == '0 &&
             pending_mul_op == teev_pkg::OP_NONE && !overflow_seen)
    else $error("expression state not cleared after a result");
`endif

endmodule
